FILE: hw/rtl/mpsd_pkg.sv
package mpsd_pkg;

	localparam int NUM_PINS   = 8;
	localparam int TIMER_BITS = 16;
	localparam int CFG_W      = 16;
	localparam int CFG_IDX_W  = 2;

	localparam logic [63:0] TMAX = (64'd1 << TIMER_BITS) - 64'd1;

	localparam logic [CFG_W-1:0] SETTLE_RESET = CFG_W'(20);
	localparam logic [CFG_W-1:0] ERROR_RESET  = CFG_W'(1000);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SETTLE_TIME = 2'd0,
		REG_ERROR_TIME  = 2'd1,
		REG_INVERT_MASK = 2'd2,
		REG_INPUT_MASK  = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic stable;
		logic set_chg;
		logic err;
	} lane_res_t;

	function automatic logic [TIMER_BITS-1:0] load_value(input logic [CFG_W-1:0] v);
		logic [63:0] wide;
		wide = 64'(v);
		if (wide > TMAX) begin
			return TIMER_BITS'(TMAX);
		end
		return TIMER_BITS'(wide);
	endfunction

endpackage

FILE: hw/rtl/mpsd_lane.sv
module mpsd_lane (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        accept,
	input  logic                        raw,
	input  logic                        tick,
	input  logic                        invert,
	input  logic                        enable,
	input  logic [mpsd_pkg::CFG_W-1:0]  settle_time,
	input  logic [mpsd_pkg::CFG_W-1:0]  error_time,
	output mpsd_pkg::lane_res_t         res
);
	import mpsd_pkg::*;

	logic                  last_q, stable_q, srun_q, erun_q;
	logic [TIMER_BITS-1:0] scnt_q, ecnt_q;

	logic                  last_d, stable_d, srun_d, erun_d, sample, set_chg, err;
	logic [TIMER_BITS-1:0] scnt_d, ecnt_d;

	always_comb begin
		last_d   = last_q;
		stable_d = stable_q;
		srun_d   = srun_q;
		erun_d   = erun_q;
		scnt_d   = scnt_q;
		ecnt_d   = ecnt_q;
		set_chg  = 1'b0;
		err      = 1'b0;
		sample   = raw ^ invert;
		if (tick) begin
			if (srun_q && scnt_q != '0) begin
				scnt_d = scnt_q - TIMER_BITS'(1);
			end
			if (erun_q && ecnt_q != '0) begin
				ecnt_d = ecnt_q - TIMER_BITS'(1);
			end
		end
		if (enable) begin
			if (sample != last_q) begin
				scnt_d = load_value(settle_time);
				srun_d = 1'b1;
				last_d = sample;
				if (!erun_q) begin
					ecnt_d = load_value(error_time);
					erun_d = 1'b1;
				end
			end else if (srun_d && scnt_d == '0) begin
				srun_d = 1'b0;
				if (last_q != stable_q) begin
					stable_d = last_q;
					set_chg  = 1'b1;
				end
				erun_d = 1'b0;
			end
			if (erun_d && ecnt_d == '0) begin
				erun_d = 1'b0;
				srun_d = 1'b0;
				err    = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q   <= 1'b0;
			stable_q <= 1'b0;
			srun_q   <= 1'b0;
			erun_q   <= 1'b0;
			scnt_q   <= '0;
			ecnt_q   <= '0;
		end else if (accept) begin
			last_q   <= last_d;
			stable_q <= stable_d;
			srun_q   <= srun_d;
			erun_q   <= erun_d;
			scnt_q   <= scnt_d;
			ecnt_q   <= ecnt_d;
		end
	end

	assign res = '{stable: stable_d, set_chg: set_chg, err: err};

endmodule

FILE: hw/rtl/mpsd_merge.sv
module mpsd_merge (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           accept,
	input  mpsd_pkg::lane_res_t            lanes [mpsd_pkg::NUM_PINS],
	input  logic [mpsd_pkg::NUM_PINS-1:0]  clear,
	input  logic                           out_ready,
	output logic                           out_valid,
	output logic [3*mpsd_pkg::NUM_PINS-1:0] out_data
);
	import mpsd_pkg::*;

	logic [NUM_PINS-1:0]   stable, set_chg, err, chg_next, chg_q;
	logic [3*NUM_PINS-1:0] data_q;
	logic                  valid_q;

	always_comb begin
		for (int i = 0; i < NUM_PINS; i++) begin
			stable[i]  = lanes[i].stable;
			set_chg[i] = lanes[i].set_chg;
			err[i]     = lanes[i].err;
		end
		chg_next = chg_q | set_chg;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chg_q   <= '0;
			valid_q <= 1'b0;
		end else if (accept) begin
			chg_q   <= chg_next & ~clear;
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			data_q <= {err, chg_next, stable};
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;

endmodule

FILE: hw/rtl/multi_pin_switch_debouncer.sv
// Debouncer for eight switch pins with a settle timer and a bounce-error timer per pin.
// Input channel s_*: one beat per sample, s_tdata carries the raw pin levels and the
// change flags to clear, s_tuser carries the millisecond tick.
// Output channel m_*: one beat per input beat with the debounced levels, the sticky
// change flags as they stood before the requested clear, and the error pulses.
// Configuration: cfg_we with cfg_index and cfg_data writes one register in a cycle;
// writes should only be made while no beat is in flight.
// The eight lanes evaluate a sample in the cycle it is accepted and the merge stage
// registers the packed result.
// Throughput is one beat per cycle; the output register is the only stage, so a new
// beat is taken whenever the output register is empty or is being emptied.
// When the receiver stalls, the result is held and s_tready drops until it is taken.
// Reset clears all pin state and flags, loads the register defaults (settle time 20,
// error time 1000, no inversion, all pins disabled) and empties the output register.
module multi_pin_switch_debouncer (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// raw_levels [7:0], clear_changes [15:8]
	input  logic [15:0]                     s_tdata,
	// ms_tick
	input  logic                            s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// stable_levels [7:0], change_flags [15:8], error_pulses [23:16]
	output logic [23:0]                     m_tdata,
	input  logic                            cfg_we,
	input  logic [mpsd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mpsd_pkg::CFG_W-1:0]      cfg_data
);
	import mpsd_pkg::*;

	logic [CFG_W-1:0]    settle_time_q, error_time_q;
	logic [NUM_PINS-1:0] invert_q, enable_q;
	logic                accept;
	lane_res_t           lanes [NUM_PINS];
	logic [NUM_PINS-1:0] lane_err, lane_set;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_time_q <= SETTLE_RESET;
			error_time_q  <= ERROR_RESET;
			invert_q      <= '0;
			enable_q      <= '0;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_SETTLE_TIME: settle_time_q <= cfg_data;
				REG_ERROR_TIME:  error_time_q  <= cfg_data;
				REG_INVERT_MASK: invert_q      <= cfg_data[NUM_PINS-1:0];
				REG_INPUT_MASK:  enable_q      <= cfg_data[NUM_PINS-1:0];
				default: ;
			endcase
		end
	end

	assign s_tready = !m_tvalid || m_tready;
	assign accept   = s_tvalid && s_tready;

	for (genvar i = 0; i < NUM_PINS; i++) begin : g_lane
		mpsd_lane u_lane (
			.clk         (clk),
			.arst_n      (arst_n),
			.accept      (accept),
			.raw         (s_tdata[i]),
			.tick        (s_tuser),
			.invert      (invert_q[i]),
			.enable      (enable_q[i]),
			.settle_time (settle_time_q),
			.error_time  (error_time_q),
			.res         (lanes[i])
		);
		assign lane_err[i] = lanes[i].err;
		assign lane_set[i] = lanes[i].set_chg;
	end

	mpsd_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.lanes     (lanes),
		.clear     (s_tdata[2*NUM_PINS-1:NUM_PINS]),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.out_data  (m_tdata)
	);

	a_ready_follows_output: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready))
		else $error("s_tready does not follow the output register state");

	a_accept_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> m_tvalid)
		else $error("accepted beat produced no result");

	a_no_error_with_change: assert property (@(posedge clk) disable iff (!arst_n)
		(lane_err & lane_set) == '0)
		else $error("a pin settled and flagged an error on the same beat");

	a_disabled_pins_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		((lane_err | lane_set) & ~enable_q) == '0)
		else $error("a disabled pin reported a change or an error");

endmodule
